FILE: sv/sbfx_pkg.sv
// shared types and constants of the sprite blitter
`default_nettype none
package sbfx_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_PIXEL = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_DEFAULT = 2'd0,
    MODE_FLIPPED = 2'd1,
    MODE_NOMASK  = 2'd2,
    MODE_BEHIND  = 2'd3
  } mode_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_REFUSED   = 2'd1;
  localparam logic [1:0] STAT_NO_SPRITE = 2'd2;

  // effect flag bit positions
  localparam int FX_CENTRED = 7;
  localparam int FX_UNSUPP  = 6;
  localparam int FX_BEHIND  = 5;
  localparam int FX_FLIPPED = 2;
  localparam int FX_NOMASK  = 1;

  localparam logic [7:0] BEHIND_KEY = 8'hFF;

  localparam int COORD_W    = 12;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // one request on its way to the frame store
  typedef struct packed {
    opcode_t                     op;
    mode_t                       mode;
    logic signed [COORD_W-1:0]   tx;
    logic signed [COORD_W-1:0]   ty;
    logic                        on_screen;
    logic [7:0]                  colour;
    logic [1:0]                  status;
    logic                        done;
  } req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] status;
    logic       sprite_done;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/sbfx_if.sv
// request and result channel interfaces
`default_nettype none
interface sbfx_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [9:0] pos_x;
  logic signed [9:0] pos_y;
  logic [7:0]        sprite_width;
  logic [7:0]        sprite_height;
  logic [7:0]        effects;
  logic [7:0]        pixel_value;

  modport source (output valid, opcode, pos_x, pos_y, sprite_width, sprite_height,
                  effects, pixel_value, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, sprite_width, sprite_height,
                effects, pixel_value, output ready);
endinterface

interface sbfx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic [1:0] status;
  logic       sprite_done;

  modport source (output valid, read_value, status, sprite_done, input ready);
  modport sink (input valid, read_value, status, sprite_done, output ready);
endinterface
`default_nettype wire

FILE: sv/sprite_blitter_with_effects_top.sv
// path: an accepted request is registered in stage 1, then stage 2, then the result queue
// throughput: one request per cycle while results are taken; the frame store port
//   does one read and one write each cycle, one read-modify-write per request
// reset: synchronous, active low; afterwards a clearing sweep writes zero to every
//   frame store byte, SCREEN_WIDTH*SCREEN_HEIGHT in all (64000 by default), with in_chan.ready low
`default_nettype none
module sprite_blitter_with_effects_top #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sbfx_in_if.sink     in_chan,
  sbfx_out_if.source  out_chan
);

  // stage 1: sprite state update and target coordinates
  sbfx_pkg::req_t                      s1_req;
  logic                                s1_valid;
  // stage 2: frame store read data back, write decision
  logic                                s2_valid;
  logic                                clr_busy;
  logic                                res_valid;
  sbfx_pkg::res_t                      res;
  logic [sbfx_pkg::FIFO_CNT_W-1:0]     fifo_count;
  logic [sbfx_pkg::FIFO_CNT_W:0]       committed;
  logic                                can_take;

  // every request in flight already holds a queue slot, so the pipeline never stalls
  assign committed = {1'b0, fifo_count}
                   + (sbfx_pkg::FIFO_CNT_W + 1)'(s1_valid)
                   + (sbfx_pkg::FIFO_CNT_W + 1)'(s2_valid);
  assign can_take  = !clr_busy && (committed < (sbfx_pkg::FIFO_CNT_W + 1)'(sbfx_pkg::FIFO_DEPTH));

  // begin requests latch the sprite, pixel requests walk its rows and columns
  sbfx_draw_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .can_take    (can_take),
    .req_r       (s1_req),
    .req_valid_r (s1_valid)
  );

  // frame store: read in stage 1, modify and write back in stage 2,
  // with the previous cycle's write forwarded on an address match
  sbfx_frame_rmw #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_rmw (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (s1_req),
    .req_valid  (s1_valid),
    .s2_valid_r (s2_valid),
    .clr_busy_r (clr_busy),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result queue decouples the pipeline from output backpressure
  sbfx_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_chan  (out_chan),
    .count_r   (fifo_count)
  );

endmodule
`default_nettype wire

FILE: sv/sbfx_draw_ctrl.sv
// sprite state and target coordinate generation
`default_nettype none
module sbfx_draw_ctrl #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sbfx_in_if.sink         in_chan,
  input  wire logic       can_take,
  output sbfx_pkg::req_t  req_r,
  output logic            req_valid_r
);

  localparam logic signed [sbfx_pkg::COORD_W-1:0] SCR_W = sbfx_pkg::COORD_W'(SCREEN_WIDTH);
  localparam logic signed [sbfx_pkg::COORD_W-1:0] SCR_H = sbfx_pkg::COORD_W'(SCREEN_HEIGHT);

  logic signed [9:0]    origin_x_r, origin_x_nxt;
  logic signed [9:0]    origin_y_r, origin_y_nxt;
  logic [7:0]           width_r, width_nxt;
  logic [7:0]           height_r, height_nxt;
  sbfx_pkg::mode_t      mode_r, mode_nxt;
  logic [7:0]           col_r, col_nxt;
  logic [7:0]           row_r, row_nxt;
  logic                 active_r, active_nxt;
  sbfx_pkg::req_t       req_nxt;

  logic                 accept;
  logic signed [10:0]   cx, cy;
  logic [8:0]           col_inc, row_inc;
  logic signed [sbfx_pkg::COORD_W-1:0] ox_ext, oy_ext, col_ext, row_ext;
  logic signed [sbfx_pkg::COORD_W-1:0] tx, ty;
  logic                 in_bounds;

  function automatic logic signed [9:0] sat10(input logic signed [10:0] v);
    logic signed [9:0] r;
    if (v < -11'sd512) begin
      r = -10'sd512;
    end else if (v > 11'sd511) begin
      r = 10'sd511;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  assign in_chan.ready = can_take;
  assign accept        = in_chan.valid && can_take;

  // centred anchor moves back by half the size
  assign cx = in_chan.effects[sbfx_pkg::FX_CENTRED]
              ? {in_chan.pos_x[9], in_chan.pos_x} - $signed({4'b0, in_chan.sprite_width[7:1]})
              : {in_chan.pos_x[9], in_chan.pos_x};
  assign cy = in_chan.effects[sbfx_pkg::FX_CENTRED]
              ? {in_chan.pos_y[9], in_chan.pos_y} - $signed({4'b0, in_chan.sprite_height[7:1]})
              : {in_chan.pos_y[9], in_chan.pos_y};

  assign col_inc = {1'b0, col_r} + 9'd1;
  assign row_inc = {1'b0, row_r} + 9'd1;
  assign ox_ext  = {{2{origin_x_r[9]}}, origin_x_r};
  assign oy_ext  = {{2{origin_y_r[9]}}, origin_y_r};
  assign col_ext = {4'b0, col_r};
  assign row_ext = {4'b0, row_r};

  always_comb begin
    unique case (sbfx_pkg::opcode_t'(in_chan.opcode))
      sbfx_pkg::OP_PIXEL: begin
        tx = (mode_r == sbfx_pkg::MODE_FLIPPED) ? ox_ext - 12'sd1 - col_ext : ox_ext + col_ext;
        ty = oy_ext + row_ext;
      end
      default: begin
        tx = {{2{in_chan.pos_x[9]}}, in_chan.pos_x};
        ty = {{2{in_chan.pos_y[9]}}, in_chan.pos_y};
      end
    endcase
  end

  assign in_bounds = (tx >= 12'sd0) && (tx < SCR_W) && (ty >= 12'sd0) && (ty < SCR_H);

  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    mode_nxt     = mode_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    active_nxt   = active_r;

    req_nxt.op        = sbfx_pkg::opcode_t'(in_chan.opcode);
    req_nxt.mode      = mode_r;
    req_nxt.tx        = tx;
    req_nxt.ty        = ty;
    req_nxt.on_screen = 1'b0;
    req_nxt.colour    = in_chan.pixel_value;
    req_nxt.status    = sbfx_pkg::STAT_OK;
    req_nxt.done      = 1'b0;

    unique case (sbfx_pkg::opcode_t'(in_chan.opcode))
      sbfx_pkg::OP_BEGIN: begin
        if (in_chan.effects[sbfx_pkg::FX_UNSUPP]) begin
          req_nxt.status = sbfx_pkg::STAT_REFUSED;
          active_nxt     = 1'b0;
        end else begin
          origin_x_nxt = sat10(cx);
          origin_y_nxt = sat10(cy);
          width_nxt    = in_chan.sprite_width;
          height_nxt   = in_chan.sprite_height;
          priority if (in_chan.effects[sbfx_pkg::FX_FLIPPED]) begin
            mode_nxt = sbfx_pkg::MODE_FLIPPED;
          end else if (in_chan.effects[sbfx_pkg::FX_NOMASK]) begin
            mode_nxt = sbfx_pkg::MODE_NOMASK;
          end else if (in_chan.effects[sbfx_pkg::FX_BEHIND]) begin
            mode_nxt = sbfx_pkg::MODE_BEHIND;
          end else begin
            mode_nxt = sbfx_pkg::MODE_DEFAULT;
          end
          col_nxt    = '0;
          row_nxt    = '0;
          active_nxt = (in_chan.sprite_width != 8'd0) && (in_chan.sprite_height != 8'd0);
        end
      end
      sbfx_pkg::OP_PIXEL: begin
        if (!active_r) begin
          req_nxt.status = sbfx_pkg::STAT_NO_SPRITE;
        end else begin
          req_nxt.on_screen = in_bounds;
          if (col_inc >= {1'b0, width_r}) begin
            col_nxt = '0;
            if (row_inc >= {1'b0, height_r}) begin
              row_nxt      = '0;
              active_nxt   = 1'b0;
              req_nxt.done = 1'b1;
            end else begin
              row_nxt = row_inc[7:0];
            end
          end else begin
            col_nxt = col_inc[7:0];
          end
        end
      end
      sbfx_pkg::OP_READ: begin
        req_nxt.on_screen = in_bounds;
      end
      sbfx_pkg::OP_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      width_r     <= '0;
      height_r    <= '0;
      mode_r      <= sbfx_pkg::MODE_DEFAULT;
      col_r       <= '0;
      row_r       <= '0;
      active_r    <= 1'b0;
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= accept;
      if (accept) begin
        origin_x_r <= origin_x_nxt;
        origin_y_r <= origin_y_nxt;
        width_r    <= width_nxt;
        height_r   <= height_nxt;
        mode_r     <= mode_nxt;
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        active_r   <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/sbfx_frame_rmw.sv
// frame store memory with read-modify-write pipeline and clearing sweep
`default_nettype none
module sbfx_frame_rmw #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sbfx_pkg::req_t  req,
  input  wire logic            req_valid,
  output logic                 s2_valid_r,
  output logic                 clr_busy_r,
  output logic                 res_valid,
  output sbfx_pkg::res_t       res
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);

  logic [7:0]      mem [0:DEPTH-1];

  logic [AW-1:0]   clr_addr_r;
  logic [AW-1:0]   s1_addr;
  logic            rd_en;
  logic [7:0]      rdata_r;

  sbfx_pkg::req_t  s2_req_r;
  logic [AW-1:0]   s2_addr_r;

  logic            fwd_valid_r;
  logic [AW-1:0]   fwd_addr_r;
  logic [7:0]      fwd_data_r;

  logic [7:0]      cur;
  logic            wr_en;

  assign s1_addr = AW'(AW'(req.ty[YW-1:0]) * AW'(SCREEN_WIDTH)) + AW'(req.tx[XW-1:0]);
  assign rd_en   = req_valid && req.on_screen;

  // the write issued at the edge of this item's read is not yet in the array
  assign cur = (fwd_valid_r && (fwd_addr_r == s2_addr_r)) ? fwd_data_r : rdata_r;

  always_comb begin
    wr_en = 1'b0;
    if (s2_valid_r && (s2_req_r.op == sbfx_pkg::OP_PIXEL) && s2_req_r.on_screen) begin
      unique case (s2_req_r.mode)
        sbfx_pkg::MODE_NOMASK:  wr_en = 1'b1;
        sbfx_pkg::MODE_BEHIND:  wr_en = (cur == sbfx_pkg::BEHIND_KEY);
        sbfx_pkg::MODE_DEFAULT,
        sbfx_pkg::MODE_FLIPPED: wr_en = (s2_req_r.colour != 8'd0);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= 8'd0;
    end else if (wr_en) begin
      mem[s2_addr_r] <= s2_req_r.colour;
    end
    if (rd_en) begin
      rdata_r <= mem[s1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + AW'(1);
        end
      end
      s2_valid_r  <= req_valid;
      fwd_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    s2_req_r   <= req;
    s2_addr_r  <= s1_addr;
    fwd_addr_r <= s2_addr_r;
    fwd_data_r <= s2_req_r.colour;
  end

  assign res_valid       = s2_valid_r;
  assign res.read_value  = ((s2_req_r.op == sbfx_pkg::OP_READ) && s2_req_r.on_screen) ? cur : 8'd0;
  assign res.status      = s2_req_r.status;
  assign res.sprite_done = s2_req_r.done;

endmodule
`default_nettype wire

FILE: sv/sbfx_out_fifo.sv
// small result queue that drives the result channel
`default_nettype none
module sbfx_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire sbfx_pkg::res_t                push_data,
  sbfx_out_if.source                         out_chan,
  output logic [sbfx_pkg::FIFO_CNT_W-1:0]    count_r
);

  sbfx_pkg::res_t                    slots [sbfx_pkg::FIFO_DEPTH];
  logic [sbfx_pkg::FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [sbfx_pkg::FIFO_PTR_W-1:0]   rd_ptr_r;
  logic                              pop;
  sbfx_pkg::res_t                    head;

  assign head                 = slots[rd_ptr_r];
  assign out_chan.valid       = (count_r != '0);
  assign out_chan.read_value  = head.read_value;
  assign out_chan.status      = head.status;
  assign out_chan.sprite_done = head.sprite_done;
  assign pop                  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + sbfx_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + sbfx_pkg::FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + sbfx_pkg::FIFO_CNT_W'(1);
        2'b01:   count_r <= count_r - sbfx_pkg::FIFO_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_sprite_blitter_with_effects_top.sv
// testbench of the sprite blitter: directed table, then random sprite traffic checked on a shadow frame
`timescale 1ns / 1ps
module tb_sprite_blitter_with_effects_top;
  import sbfx_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int SCREEN_WIDTH   = 320;
  localparam int SCREEN_HEIGHT  = 200;
  localparam int FRAME_BYTES    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ITEM_TARGET    = 850;
  localparam int CALM_TAIL      = 130;    // last requests run with no idling on either side
  localparam int LONG_HOLD      = 400;    // long result back-pressure, in cycles
  localparam int SETTLE_CYCLES  = 24;     // pipeline is 3 deep, leave plenty of slack
  localparam int WATCHDOG_LIMIT = 200000; // the clearing sweep alone moves nothing, so the limit sits above its length

  // effect flag masks built from the package bit positions
  localparam logic [7:0] FXM_CENTRED = 8'(1 << FX_CENTRED);
  localparam logic [7:0] FXM_UNSUPP  = 8'(1 << FX_UNSUPP);
  localparam logic [7:0] FXM_BEHIND  = 8'(1 << FX_BEHIND);
  localparam logic [7:0] FXM_FLIPPED = 8'(1 << FX_FLIPPED);
  localparam logic [7:0] FXM_NOMASK  = 8'(1 << FX_NOMASK);

  // one request as the sender sees it
  typedef struct packed {
    opcode_t           op;
    logic signed [9:0] x;
    logic signed [9:0] y;
    logic [7:0]        w;
    logic [7:0]        h;
    logic [7:0]        fx;
    logic [7:0]        colour;
  } blit_req_t;

  // directed row: request plus, where obvious, the result typed in by hand
  typedef struct packed {
    blit_req_t req;
    logic      has_known;
    res_t      known_res;
  } blit_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sbfx_in_if  in_chan ();
  sbfx_out_if out_chan ();

  sprite_blitter_with_effects_top #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow copy of the block: frame store plus the latched sprite
  logic [7:0]  shadow_frame [FRAME_BYTES];
  int          org_x;
  int          org_y;
  int unsigned spr_w;
  int unsigned spr_h;
  int unsigned col_cnt;
  int unsigned row_cnt;
  mode_t       spr_mode;
  bit          spr_live;

  res_t        frame_results_q [$]; // results owed by the block, oldest first
  blit_row_t   blit_rows [$];
  int          mismatches;
  int          accepted_items;
  int          quiet_cycles;
  bit          idle_on;
  bit          long_hold_pending;

  function automatic bit on_screen(int x, int y);
    return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
  endfunction

  function automatic int clamp_anchor(int v);
    if (v < -512) return -512;
    if (v > 511) return 511;
    return v;
  endfunction

  // apply one request to the shadow state and return the result it owes
  function automatic res_t blit_step(blit_req_t r);
    res_t res;
    int   ax;
    int   ay;
    int   tx;
    int   ty;
    int   addr;
    res = '0;
    case (r.op)
      OP_BEGIN: begin
        if (r.fx[FX_UNSUPP]) begin
          res.status = STAT_REFUSED;
          spr_live   = 1'b0;
        end else begin
          ax = $signed(r.x);
          ay = $signed(r.y);
          if (r.fx[FX_CENTRED]) begin
            ax = ax - int'(r.w >> 1);
            ay = ay - int'(r.h >> 1);
          end
          org_x = clamp_anchor(ax);
          org_y = clamp_anchor(ay);
          spr_w = r.w;
          spr_h = r.h;
          // flipped beats no-mask beats behind
          if (r.fx[FX_FLIPPED]) spr_mode = MODE_FLIPPED;
          else if (r.fx[FX_NOMASK]) spr_mode = MODE_NOMASK;
          else if (r.fx[FX_BEHIND]) spr_mode = MODE_BEHIND;
          else spr_mode = MODE_DEFAULT;
          col_cnt  = 0;
          row_cnt  = 0;
          spr_live = (r.w != 8'd0) && (r.h != 8'd0);
        end
      end
      OP_PIXEL: begin
        if (!spr_live) begin
          res.status = STAT_NO_SPRITE;
        end else begin
          ty = org_y + int'(row_cnt);
          tx = (spr_mode == MODE_FLIPPED) ? org_x - 1 - int'(col_cnt) : org_x + int'(col_cnt);
          if (on_screen(tx, ty)) begin
            addr = ty * SCREEN_WIDTH + tx;
            case (spr_mode)
              MODE_NOMASK: shadow_frame[addr] = r.colour;
              MODE_BEHIND: if (shadow_frame[addr] == BEHIND_KEY) shadow_frame[addr] = r.colour;
              default: if (r.colour != 8'd0) shadow_frame[addr] = r.colour;
            endcase
          end
          // off-screen pixels still advance the raster
          col_cnt++;
          if (col_cnt >= spr_w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= spr_h) begin
              row_cnt         = 0;
              spr_live        = 1'b0;
              res.sprite_done = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        tx = $signed(r.x);
        ty = $signed(r.y);
        if (on_screen(tx, ty)) res.read_value = shadow_frame[ty * SCREEN_WIDTH + tx];
      end
      default: ; // unused opcode: all fields zero
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_row(opcode_t op, int x, int y, int w, int h, logic [7:0] fx,
                         logic [7:0] colour, bit has_known, logic [7:0] rv,
                         logic [1:0] st, bit dn);
    blit_row_t row;
    row.req.op                  = op;
    row.req.x                   = 10'(x);
    row.req.y                   = 10'(y);
    row.req.w                   = 8'(w);
    row.req.h                   = 8'(h);
    row.req.fx                  = fx;
    row.req.colour              = colour;
    row.has_known               = has_known;
    row.known_res.read_value    = rv;
    row.known_res.status        = st;
    row.known_res.sprite_done   = dn;
    blit_rows.push_back(row);
  endtask

  // present one request and hold it until accepted, then book its result
  task automatic send_req(blit_req_t r, bit has_known, res_t known_res);
    res_t res;
    in_chan.valid         <= 1'b1;
    in_chan.opcode        <= r.op;
    in_chan.pos_x         <= r.x;
    in_chan.pos_y         <= r.y;
    in_chan.sprite_width  <= r.w;
    in_chan.sprite_height <= r.h;
    in_chan.effects       <= r.fx;
    in_chan.pixel_value   <= r.colour;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    res = blit_step(r);
    frame_results_q.push_back(has_known ? known_res : res);
    accepted_items++;
  endtask

  // random sender gap, only while idle_on is set
  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic offer(blit_req_t r);
    idle_gap();
    send_req(r, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_colour();
    // plenty of transparent and behind-key colours so every mode has work
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return BEHIND_KEY;
      default: return 8'($urandom);
    endcase
  endfunction

  // coordinate biased to a hot corner and the far edge so sprites overlap and clip
  function automatic logic signed [9:0] pick_coord(int span);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'($urandom_range(0, 36)) - 6;
      5, 6:          v = span - 20 + int'($urandom_range(0, 26));
      7, 8:          v = int'($urandom_range(0, span + 15)) - 8;
      default:       v = int'($urandom_range(0, 1023)) - 512;
    endcase
    return 10'(v);
  endfunction

  function automatic blit_req_t noise_req();
    blit_req_t r;
    r.op     = opcode_t'($urandom_range(0, 3));
    r.x      = 10'($urandom);
    r.y      = 10'($urandom);
    r.w      = 8'($urandom);
    r.h      = 8'($urandom);
    r.fx     = 8'($urandom);
    r.colour = 8'($urandom);
    return r;
  endfunction

  // begin, the sprite's pixels (now and then cut short), then reads around it
  task automatic random_sprite();
    blit_req_t r;
    int        w;
    int        h;
    int        n;
    int        stop_at;
    int        ax;
    int        ay;
    r = noise_req();
    r.op = OP_BEGIN;
    r.x  = pick_coord(SCREEN_WIDTH);
    r.y  = pick_coord(SCREEN_HEIGHT);
    if ($urandom_range(0, 29) == 0) begin
      // a few long strips reach the top size bit
      if ($urandom_range(0, 1)) begin
        w = $urandom_range(128, 255);
        h = 1;
      end else begin
        w = 1;
        h = $urandom_range(128, 255);
      end
    end else begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
    end
    r.w  = 8'(w);
    r.h  = 8'(h);
    r.fx = 8'($urandom) & ~(FXM_UNSUPP | FXM_FLIPPED | FXM_NOMASK | FXM_BEHIND);
    case ($urandom_range(0, 3))
      0: ;
      1: r.fx |= FXM_BEHIND;
      2: r.fx |= FXM_NOMASK | (8'($urandom) & FXM_BEHIND);
      default: r.fx |= FXM_FLIPPED | (8'($urandom) & (FXM_NOMASK | FXM_BEHIND));
    endcase
    ax = $signed(r.x);
    ay = $signed(r.y);
    offer(r);
    stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h - 1) : w * h;
    for (n = 0; n < stop_at; n++) begin
      r        = noise_req();
      r.op     = OP_PIXEL;
      r.colour = pick_colour();
      offer(r);
    end
    repeat ($urandom_range(1, 3)) begin
      r    = noise_req();
      r.op = OP_READ;
      r.x  = 10'(ax - w + int'($urandom_range(0, 2 * w)));
      r.y  = 10'(ay - h + int'($urandom_range(0, 2 * h)));
      offer(r);
    end
  endtask

  // result side: random back-pressure bursts, and one long hold on request
  initial begin : result_taker
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left         = LONG_HOLD - 1;
        out_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 17);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // result checker: every accepted result against the oldest one owed
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch("result with no request outstanding, read_value",
                        out_chan.read_value, 8'd0);
      end else begin
        want = frame_results_q.pop_front();
        if (out_chan.read_value !== want.read_value)
          report_mismatch("read_value", out_chan.read_value, want.read_value);
        if (out_chan.status !== want.status)
          report_mismatch("status", 8'(out_chan.status), 8'(want.status));
        if (out_chan.sprite_done !== want.sprite_done)
          report_mismatch("sprite_done", 8'(out_chan.sprite_done), 8'(want.sprite_done));
      end
    end
  end

  // watchdog: too long with no request and no result moving
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sprite_blitter_with_effects_top test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int        k;
    int        pick;
    bit        hold_done;
    bit        drain_done;
    blit_req_t r;

    // everything the block sees is known from time zero
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.opcode        <= OP_NONE;
    in_chan.pos_x         <= '0;
    in_chan.pos_y         <= '0;
    in_chan.sprite_width  <= '0;
    in_chan.sprite_height <= '0;
    in_chan.effects       <= '0;
    in_chan.pixel_value   <= '0;

    // shadow state after reset
    foreach (shadow_frame[i]) shadow_frame[i] = 8'd0;
    org_x             = 0;
    org_y             = 0;
    spr_w             = 0;
    spr_h             = 0;
    col_cnt           = 0;
    row_cnt           = 0;
    spr_mode          = MODE_DEFAULT;
    spr_live          = 1'b0;
    mismatches        = 0;
    accepted_items    = 0;
    quiet_cycles      = 0;
    idle_on           = 1'b1;
    long_hold_pending = 1'b0;
    hold_done         = 1'b0;
    drain_done        = 1'b0;

    // directed table: op, x, y, w, h, effects, colour, typed-in?, read_value, status, done
    // corners read back zero from the cleared store; far extremes are off screen and read zero
    add_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'h00, 1, 8'h00, STAT_OK, 0);
    add_row(OP_READ, 319, 199, 0, 0, 8'h00, 8'h00, 1, 8'h00, STAT_OK, 0);
    add_row(OP_READ, -512, -512, 255, 255, 8'hFF, 8'hFF, 1, 8'h00, STAT_OK, 0);
    add_row(OP_READ, 511, 511, 0, 0, 8'h00, 8'h00, 1, 8'h00, STAT_OK, 0);
    // pixel before any sprite
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'hAA, 1, 8'h00, STAT_NO_SPRITE, 0);
    // unsupported flag refuses, and leaves nothing active
    add_row(OP_BEGIN, 10, 10, 4, 4, 8'hFF, 8'h00, 1, 8'h00, STAT_REFUSED, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h11, 1, 8'h00, STAT_NO_SPRITE, 0);
    // zero width sprite is empty
    add_row(OP_BEGIN, 3, 3, 0, 5, 8'h00, 8'h00, 1, 8'h00, STAT_OK, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h12, 1, 8'h00, STAT_NO_SPRITE, 0);
    // single pixel sprite, default mode, read back
    add_row(OP_BEGIN, 0, 0, 1, 1, 8'h00, 8'h00, 1, 8'h00, STAT_OK, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h55, 1, 8'h00, STAT_OK, 1);
    add_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'h00, 1, 8'h55, STAT_OK, 0);
    // no-mask strip at the bottom right corner, second pixel clipped
    add_row(OP_BEGIN, 319, 199, 2, 1, FXM_NOMASK, 8'h00, 1, 8'h00, STAT_OK, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'hFF, 0, 8'h00, STAT_OK, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'hFF, 0, 8'h00, STAT_OK, 0);
    // behind mode lands on the key colour left above
    add_row(OP_BEGIN, 319, 199, 1, 1, FXM_BEHIND, 8'h00, 1, 8'h00, STAT_OK, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h22, 1, 8'h00, STAT_OK, 1);
    add_row(OP_READ, 319, 199, 0, 0, 8'h00, 8'h00, 1, 8'h22, STAT_OK, 0);
    // flipped sprite runs leftward off the left edge
    add_row(OP_BEGIN, 1, 0, 2, 1, FXM_FLIPPED | FXM_NOMASK, 8'h00, 0, 8'h00, STAT_OK, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h33, 0, 8'h00, STAT_OK, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h00, 0, 8'h00, STAT_OK, 0);
    add_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'h00, 0, 8'h00, STAT_OK, 0);
    // centred at the low extreme saturates the anchor, then gets abandoned
    add_row(OP_BEGIN, -512, -512, 255, 255, FXM_CENTRED, 8'h00, 1, 8'h00, STAT_OK, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h77, 0, 8'h00, STAT_OK, 0);
    // small centred sprite, abandoned after one pixel
    add_row(OP_BEGIN, 5, 5, 2, 2, FXM_CENTRED | FXM_NOMASK, 8'h00, 1, 8'h00, STAT_OK, 0);
    add_row(OP_PIXEL, 0, 0, 0, 0, 8'h00, 8'h44, 0, 8'h00, STAT_OK, 0);
    add_row(OP_READ, 4, 4, 0, 0, 8'h00, 8'h00, 0, 8'h00, STAT_OK, 0);
    // unused opcode answers all zero
    add_row(OP_NONE, 100, 50, 9, 9, 8'h0F, 8'h99, 1, 8'h00, STAT_OK, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // the clearing sweep keeps in_chan.ready low; send_req simply waits it out
    for (k = 0; k < blit_rows.size(); k++) begin
      idle_gap();
      send_req(blit_rows[k].req, blit_rows[k].has_known, blit_rows[k].known_res);
    end

    // random part: mostly whole sprites, some reads and some noise
    while (accepted_items < ITEM_TARGET) begin
      idle_on = (accepted_items < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 4) != 0);
      if (!hold_done && accepted_items >= 300) begin
        // receiver stalls for a long stretch while requests keep coming
        long_hold_pending = 1'b1;
        hold_done         = 1'b1;
      end
      if (!drain_done && accepted_items >= 550) begin
        // sender stops until the block has nothing left to deliver
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (frame_results_q.size() != 0) @(posedge clk);
        drain_done = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        random_sprite();
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 4)) begin
          r    = noise_req();
          r.op = OP_READ;
          if ($urandom_range(0, 1)) begin
            r.x = pick_coord(SCREEN_WIDTH);
            r.y = pick_coord(SCREEN_HEIGHT);
          end
          offer(r);
        end
      end else begin
        repeat ($urandom_range(1, 3)) offer(noise_req());
      end
    end

    // wind down: wait for every owed result, then a little longer for strays
    idle_on = 1'b0;
    in_chan.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("sprite_blitter_with_effects_top test passed");
    else
      $display("sprite_blitter_with_effects_top test failed");
    $finish;
  end

endmodule
